[rtl/deadline_ordered_timer_table_defines.svh]
// Assertion helpers used by the dott_back module of the timer table.
`ifndef DEADLINE_ORDERED_TIMER_TABLE_DEFINES_SVH
`define DEADLINE_ORDERED_TIMER_TABLE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define DOTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define DOTT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/dott_pkg.sv]
package dott_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned PerW   = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned MaxRes = 16;
  localparam int unsigned EntW   = PerW + TimeW;

  localparam logic [TimeW-1:0] TimeMax     = {TimeW{1'b1}};
  localparam logic [PerW-1:0]  WindowReset = 32'(60 * 60 * 1000);

  // Raw operation codes on the input port.
  localparam logic [2:0] OpcAdd     = 3'd0;
  localparam logic [2:0] OpcCancel  = 3'd1;
  localparam logic [2:0] OpcRefresh = 3'd2;
  localparam logic [2:0] OpcReset   = 3'd3;
  localparam logic [2:0] OpcExpire  = 3'd4;
  localparam logic [2:0] OpcQuery   = 3'd5;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_CANCEL,
    OP_REFRESH,
    OP_RESET,
    OP_EXPIRE,
    OP_QUERY,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NACT = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_START,
    S_SCAN,
    S_SCANW,
    S_EVAL,
    S_EMIT,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e              op;
    logic             slot_ok;
    logic [SlotW-1:0] slot;
    logic [PerW-1:0]  per;
    logic             rep;
    logic             fnow;
    logic [TimeW-1:0] now;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic             fired;
    logic [TimeW-1:0] rem;
    logic             wake;
    logic             any_active;
    logic             last;
  } res_t;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

[rtl/deadline_ordered_timer_table.sv]
// Cancel, unused codes and a full add answer without a scan; refresh reads its slot and rewrites it
// if active; reset reads it and rewrites an active timer for a new period or from now; add, query
// and such a reset then scan all timers. An expire scan runs one pass a fired timer plus a final
// pass, then emits one beat a fired slot, or a single beat if none fired; pop stalls hold results.
// One item is in the engine at a time, the next taken only once the last is answered; two items
// wait ahead of it. Reset clears all timers, the pending wake and the last scan time, sets one hour.
module deadline_ordered_timer_table import dott_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       op_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [PerW-1:0]  period_ms_i,
  input  logic             repeat_req_i,
  input  logic             from_now_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             cfg_we_i,
  input  logic [PerW-1:0]  cfg_data_i,
  output logic             empty,
  input  logic             pop,
  output logic [1:0]       status_o,
  output logic [SlotW-1:0] slot_out_o,
  output logic             fired_o,
  output logic [TimeW-1:0] remaining_ms_o,
  output logic             wake_o,
  output logic             any_active_o,
  output logic             last_o
);

  logic  item_valid, item_pop, res_push, res_full;
  item_t item;
  res_t  res_in, res_out;

  dott_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk_i, .rst_ni, .push, .full,
    .op_i, .slot_i, .period_ms_i, .repeat_req_i, .from_now_i, .now_ms_i,
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  dott_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk_i, .rst_ni,
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_we_i, .cfg_data_i,
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  dott_outq u_outq (
    .clk_i, .rst_ni,
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .pop, .empty,
    .res_o      (res_out)
  );

  assign status_o       = res_out.status;
  assign slot_out_o     = res_out.slot;
  assign fired_o        = res_out.fired;
  assign remaining_ms_o = res_out.rem;
  assign wake_o         = res_out.wake;
  assign any_active_o   = res_out.any_active;
  assign last_o         = res_out.last;

endmodule

[rtl/dott_front.sv]
module dott_front import dott_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       op_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [PerW-1:0]  period_ms_i,
  input  logic             repeat_req_i,
  input  logic             from_now_i,
  input  logic [TimeW-1:0] now_ms_i,
  output logic             item_valid_o,
  output item_t            item_o,
  input  logic             item_pop_i
);

  item_t       q_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  item_t       cls;
  logic        wr, rd;

  always_comb begin
    cls         = '0;
    cls.slot    = slot_i;
    cls.slot_ok = (32'(slot_i) < NUM_TIMERS);
    cls.per     = period_ms_i;
    cls.rep     = repeat_req_i;
    cls.fnow    = from_now_i;
    cls.now     = now_ms_i;
    unique case (op_i)
      OpcAdd:     cls.op = OP_ADD;
      OpcCancel:  cls.op = OP_CANCEL;
      OpcRefresh: cls.op = OP_REFRESH;
      OpcReset:   cls.op = OP_RESET;
      OpcExpire:  cls.op = OP_EXPIRE;
      OpcQuery:   cls.op = OP_QUERY;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign full         = (cnt_q == 2'd2);
  assign wr           = push && !full;
  assign item_valid_o = (cnt_q != 2'd0);
  assign rd           = item_pop_i && item_valid_o;
  assign item_o       = q_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) q_q[wptr_q] <= cls;
  end

endmodule

[rtl/dott_outq.sv]
module dott_outq import dott_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_push_i,
  input  res_t res_i,
  output logic res_full_o,
  input  logic pop,
  output logic empty,
  output res_t res_o
);

  res_t       q_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign wr         = res_push_i && !res_full_o;
  assign rd         = pop && !empty;
  assign res_o      = q_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) q_q[wptr_q] <= res_i;
  end

endmodule

[rtl/dott_back.sv]
`include "deadline_ordered_timer_table_defines.svh"

module dott_back import dott_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  item_t           item_i,
  output logic            item_pop_o,
  input  logic            cfg_we_i,
  input  logic [PerW-1:0] cfg_data_i,
  output logic            res_push_o,
  output res_t            res_o,
  input  logic            res_full_i
);

  localparam int unsigned IW = $clog2(NUM_TIMERS);

  state_e state_q, state_d;

  logic [NUM_TIMERS-1:0] act_q, rec_q, done_q;
  logic                  wake_pend_q;
  logic [TimeW-1:0]      prev_now_q;
  logic [PerW-1:0]       win_q;

  logic [EntW-1:0] mem_q [NUM_TIMERS];
  logic [EntW-1:0] rd_q;
  logic            mem_we;
  logic [IW-1:0]   mem_wa, mem_ra;
  logic [EntW-1:0] mem_wd;

  item_t            it_q;
  logic [IW-1:0]    sidx_q, tgt_q, idx_q, cmp_idx_q, best_idx_q;
  logic             cmp_vld_q, best_vld_q, roll_q;
  logic [TimeW-1:0] best_dl_q, start_q, rem_q;
  logic [PerW-1:0]  best_per_q;
  status_e          rstat_q;
  logic [SlotW-1:0] rslot_q;
  logic             rwake_q;
  logic [SlotW-1:0] fbuf_q [MaxRes];
  logic [4:0]       fcnt_q;
  logic [3:0]       ecnt_q;

  logic [PerW-1:0]  rd_per;
  logic [TimeW-1:0] rd_dl;
  logic [IW-1:0]    free_idx, in_sidx;
  logic             tbl_full, fire, emit_last, scan_go, same_per, wake_hit;

  assign rd_per   = rd_q[EntW-1:TimeW];
  assign rd_dl    = rd_q[TimeW-1:0];
  assign tbl_full = &act_q;
  assign in_sidx  = IW'(item_i.slot);
  assign fire     = best_vld_q && (roll_q || best_dl_q <= it_q.now) &&
                    (fcnt_q < 5'(MaxRes));
  assign emit_last = ({1'b0, ecnt_q} == fcnt_q - 5'd1);
  assign same_per  = (it_q.per == rd_per) && !it_q.fnow;
  assign wake_hit  = best_vld_q && (best_idx_q == tgt_q) && !wake_pend_q;
  assign scan_go   = (state_q != S_SCAN) && (state_d == S_SCAN);

  // Lowest inactive slot.
  always_comb begin
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!act_q[i]) free_idx = IW'(i);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.op)
            OP_ADD:               state_d = tbl_full ? S_OUT : S_SCAN;
            OP_REFRESH, OP_RESET: state_d = item_i.slot_ok ? S_RD : S_OUT;
            OP_EXPIRE, OP_QUERY:  state_d = S_SCAN;
            default:              state_d = S_OUT;
          endcase
        end
      end
      S_RD: begin
        if (it_q.op == OP_RESET && !same_per && act_q[sidx_q]) state_d = S_START;
        else state_d = S_OUT;
      end
      S_START: state_d = S_SCAN;
      S_SCAN:  if (idx_q == IW'(NUM_TIMERS - 1)) state_d = S_SCANW;
      S_SCANW: state_d = S_EVAL;
      S_EVAL: begin
        if (it_q.op == OP_EXPIRE) state_d = fire ? S_SCAN : S_EMIT;
        else state_d = S_OUT;
      end
      S_EMIT: if (!res_full_i && (fcnt_q == 5'd0 || emit_last)) state_d = S_IDLE;
      S_OUT:  if (!res_full_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o = (state_q == S_IDLE) && item_valid_i;
    mem_ra     = (state_q == S_IDLE) ? in_sidx : idx_q;
    mem_we     = 1'b0;
    mem_wa     = sidx_q;
    mem_wd     = '0;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i && item_i.op == OP_ADD && !tbl_full) begin
          mem_we = 1'b1;
          mem_wa = free_idx;
          mem_wd = {item_i.per, sat_add(item_i.now, TimeW'(item_i.per))};
        end
      end
      S_RD: begin
        if (it_q.op == OP_REFRESH && act_q[sidx_q]) begin
          mem_we = 1'b1;
          mem_wd = {rd_per, sat_add(it_q.now, TimeW'(rd_per))};
        end
      end
      S_START: begin
        mem_we = 1'b1;
        mem_wd = {it_q.per, sat_add(start_q, TimeW'(it_q.per))};
      end
      S_EVAL: begin
        if (it_q.op == OP_EXPIRE && fire && rec_q[best_idx_q]) begin
          mem_we = 1'b1;
          mem_wa = best_idx_q;
          mem_wd = {best_per_q, sat_add(it_q.now, TimeW'(best_per_q))};
        end
      end
      S_EMIT: begin
        res_push_o       = !res_full_i;
        res_o.status     = STAT_OK;
        res_o.any_active = |act_q;
        if (fcnt_q == 5'd0) begin
          res_o.last = 1'b1;
        end else begin
          res_o.slot  = fbuf_q[ecnt_q];
          res_o.fired = 1'b1;
          res_o.last  = emit_last;
        end
      end
      S_OUT: begin
        res_push_o       = !res_full_i;
        res_o.status     = rstat_q;
        res_o.slot       = rslot_q;
        res_o.rem        = rem_q;
        res_o.wake       = rwake_q;
        res_o.any_active = |act_q;
        res_o.last       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= '0;
      rec_q       <= '0;
      done_q      <= '0;
      wake_pend_q <= 1'b0;
      prev_now_q  <= '0;
      win_q       <= WindowReset;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      fcnt_q      <= '0;
      ecnt_q      <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == S_SCAN);
      if (cfg_we_i) win_q <= cfg_data_i;

      if (scan_go) begin
        idx_q      <= '0;
        best_vld_q <= 1'b0;
      end else begin
        if (state_q == S_SCAN) idx_q <= idx_q + 1'b1;
        // Strict compare keeps the lower slot on equal deadlines.
        if (cmp_vld_q && act_q[cmp_idx_q] && !done_q[cmp_idx_q] &&
            (!best_vld_q || rd_dl < best_dl_q)) begin
          best_vld_q <= 1'b1;
        end
      end

      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            done_q <= '0;
            fcnt_q <= '0;
            unique case (item_i.op)
              OP_ADD: begin
                if (!tbl_full) begin
                  act_q[free_idx] <= 1'b1;
                  rec_q[free_idx] <= item_i.rep;
                end
              end
              OP_CANCEL: if (item_i.slot_ok) act_q[in_sidx] <= 1'b0;
              OP_EXPIRE: prev_now_q <= item_i.now;
              OP_QUERY:  wake_pend_q <= 1'b0;
              default: ;
            endcase
          end
        end
        S_EVAL: begin
          if (it_q.op == OP_EXPIRE) begin
            if (fire) begin
              done_q[best_idx_q] <= 1'b1;
              if (!rec_q[best_idx_q]) act_q[best_idx_q] <= 1'b0;
              fcnt_q <= fcnt_q + 5'd1;
            end
            ecnt_q <= '0;
          end else if (it_q.op == OP_ADD || it_q.op == OP_RESET) begin
            if (wake_hit) wake_pend_q <= 1'b1;
          end
        end
        S_EMIT: if (!res_full_i) ecnt_q <= ecnt_q + 4'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    if (!scan_go && cmp_vld_q && act_q[cmp_idx_q] && !done_q[cmp_idx_q] &&
        (!best_vld_q || rd_dl < best_dl_q)) begin
      best_idx_q <= cmp_idx_q;
      best_dl_q  <= rd_dl;
      best_per_q <= rd_per;
    end
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          it_q    <= item_i;
          sidx_q  <= in_sidx;
          tgt_q   <= (item_i.op == OP_ADD) ? free_idx : in_sidx;
          rslot_q <= '0;
          rem_q   <= '0;
          rwake_q <= 1'b0;
          roll_q  <= (prev_now_q > TimeW'(win_q)) &&
                     (item_i.now < prev_now_q - TimeW'(win_q));
          unique case (item_i.op)
            OP_ADD:    rstat_q <= tbl_full ? STAT_FULL : STAT_OK;
            OP_CANCEL: rstat_q <= (item_i.slot_ok && act_q[in_sidx]) ? STAT_OK : STAT_NACT;
            OP_REFRESH, OP_RESET: rstat_q <= item_i.slot_ok ? STAT_OK : STAT_NACT;
            default:   rstat_q <= STAT_OK;
          endcase
        end
      end
      S_RD: begin
        if (it_q.op == OP_REFRESH) begin
          rstat_q <= act_q[sidx_q] ? STAT_OK : STAT_NACT;
        end else begin
          rstat_q <= (same_per || act_q[sidx_q]) ? STAT_OK : STAT_NACT;
        end
        // Restart point for a reset: now, or the previous start clamped at zero.
        if (it_q.fnow) start_q <= it_q.now;
        else if (rd_dl > TimeW'(rd_per)) start_q <= rd_dl - TimeW'(rd_per);
        else start_q <= '0;
      end
      S_EVAL: begin
        if (it_q.op == OP_EXPIRE) begin
          if (fire) fbuf_q[fcnt_q[3:0]] <= SlotW'(best_idx_q);
        end else if (it_q.op == OP_QUERY) begin
          if (!best_vld_q) rem_q <= TimeMax;
          else if (it_q.now >= best_dl_q) rem_q <= '0;
          else rem_q <= best_dl_q - it_q.now;
        end else begin
          rwake_q <= wake_hit;
          if (it_q.op == OP_ADD) rslot_q <= SlotW'(tgt_q);
        end
      end
      default: ;
    endcase
  end

  `DOTT_ASSERT_NEVER(a_fire_count, fcnt_q > 5'(MaxRes), "fired count beyond result limit")
  `DOTT_ASSERT(a_best_live, (state_q == S_EVAL && best_vld_q) |-> (act_q[best_idx_q] && !done_q[best_idx_q]), "earliest slot is not a live candidate")
  `DOTT_ASSERT(a_fire_marks, (state_q == S_EVAL && it_q.op == OP_EXPIRE && fire) |=> (state_q == S_SCAN && done_q[$past(best_idx_q)]), "fired slot not marked or scan not restarted")

endmodule
